// ===== rtl/mmwd_pkg.sv =====
package mmwd_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned ColW    = 12;
  localparam int unsigned RowW    = 13;
  localparam int unsigned CountW  = 13;
  localparam int unsigned SkipW   = 24;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 24;

  // Running extreme start values per sample mode
  localparam logic [SampleW-1:0] SMinInit  = 16'h7fff;  // 32767
  localparam logic [SampleW-1:0] SMaxInit  = 16'h8001;  // -32767
  localparam logic [SampleW-1:0] BMinInit  = 16'h00ff;  // 255
  localparam logic [SampleW-1:0] BMaxInit  = 16'h0000;
  localparam logic [SampleW-1:0] SignFlip  = 16'h8000;  // +32768 offset
  localparam logic [7:0]         ByteMask  = 8'hff;

  // Register reset values
  localparam logic [15:0]       SppReset    = 16'd0;
  localparam logic [CountW-1:0] PaReset     = 13'd900;
  localparam logic [RowW-1:0]   HeightReset = 13'd350;
  localparam logic [SkipW-1:0]  StartReset  = 24'd0;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SPP    = 3'd0,
    REG_PA     = 3'd1,
    REG_HEIGHT = 3'd2,
    REG_START  = 3'd3,
    REG_BYTE   = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [15:0]       spp;
    logic [CountW-1:0] pa;
    logic [RowW-1:0]   height;
    logic [SkipW-1:0]  start;
    logic              byte_mode;
  } cfg_t;

  typedef struct packed {
    logic [SampleW-1:0] sample_word;
    logic               last_sample;
  } smp_t;

  typedef struct packed {
    logic [ColW-1:0] x_start;
    logic [RowW-1:0] y_start;
    logic [ColW-1:0] x_end;
    logic [RowW-1:0] y_end;
    logic            final_segment;
  } seg_t;

  // Closed window: extremes are two's complement (or zero-extended bytes)
  typedef struct packed {
    logic [SampleW-1:0] vmin;
    logic [SampleW-1:0] vmax;
    logic [ColW-1:0]    col;
    logic               ends;
  } win_t;

  typedef struct packed {
    logic [RowW-1:0] row_min;
    logic [RowW-1:0] row_max;
    logic [ColW-1:0] col;
    logic            ends;
  } row_t;

  // Restart request toward the stages, with the register values now in force
  typedef struct packed {
    logic start;
    cfg_t cfg;
  } restart_t;

endpackage

// ===== rtl/mmwd_stream_if.sv =====
interface mmwd_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/mmwd_accum.sv =====
module mmwd_accum
  import mmwd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  restart_t restart_i,
  input  logic     in_valid_i,
  input  smp_t     in_data_i,
  output logic     in_ready_o,
  output logic     win_valid_o,
  output win_t     win_o,
  input  logic     win_ready_i
);

  logic [SkipW-1:0]   skip_q, skip_d;
  logic [15:0]        fill_q, fill_d;
  logic [CountW-1:0]  col_q, col_d;
  logic [SampleW-1:0] min_q, min_d;
  logic [SampleW-1:0] max_q, max_d;
  logic               done_q, done_d;
  logic               win_valid_q, win_valid_d;
  win_t               win_q, win_d;

  logic               accept;
  logic               close_fire;

  assign in_ready_o  = !win_valid_q || win_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign win_valid_o = win_valid_q;
  assign win_o       = win_q;

  always_comb begin
    logic [SampleW-1:0] lo, hi, mn, mx;
    logic [15:0]        fill_inc;
    logic [CountW:0]    col_inc;
    logic               ends;

    skip_d     = skip_q;
    fill_d     = fill_q;
    col_d      = col_q;
    min_d      = min_q;
    max_d      = max_q;
    done_d     = done_q;
    win_d      = win_q;
    close_fire = 1'b0;

    lo       = {8'h00, in_data_i.sample_word[7:0] & ByteMask};
    hi       = {8'h00, in_data_i.sample_word[15:8] & ByteMask};
    mn       = min_q;
    mx       = max_q;
    fill_inc = fill_q + 16'd1;
    col_inc  = {1'b0, col_q} + {{CountW{1'b0}}, 1'b1};
    ends     = in_data_i.last_sample || (col_inc >= {1'b0, cfg_i.pa});

    if (cfg_i.byte_mode) begin
      if (lo < mn) mn = lo;
      if (hi < mn) mn = hi;
      if (lo > mx) mx = lo;
      if (hi > mx) mx = hi;
    end else begin
      if ($signed(in_data_i.sample_word) < $signed(mn)) mn = in_data_i.sample_word;
      if ($signed(in_data_i.sample_word) > $signed(mx)) mx = in_data_i.sample_word;
    end

    if (restart_i.start) begin
      skip_d = restart_i.cfg.start;
      fill_d = '0;
      col_d  = '0;
      min_d  = restart_i.cfg.byte_mode ? BMinInit : SMinInit;
      max_d  = restart_i.cfg.byte_mode ? BMaxInit : SMaxInit;
      done_d = 1'b0;
    end else if (accept && !done_q) begin
      if (cfg_i.spp == '0 || cfg_i.pa == '0) begin
        if (in_data_i.last_sample) done_d = 1'b1;
      end else if (skip_q != '0) begin
        skip_d = skip_q - {{(SkipW-1){1'b0}}, 1'b1};
        if (in_data_i.last_sample) done_d = 1'b1;
      end else if (fill_inc < cfg_i.spp && !in_data_i.last_sample) begin
        fill_d = fill_inc;
        min_d  = mn;
        max_d  = mx;
      end else begin
        // window closes
        close_fire = 1'b1;
        win_d.vmin = mn;
        win_d.vmax = mx;
        win_d.col  = col_q[ColW-1:0];
        win_d.ends = ends;
        fill_d     = '0;
        col_d      = col_inc[CountW-1:0];
        min_d      = cfg_i.byte_mode ? BMinInit : SMinInit;
        max_d      = cfg_i.byte_mode ? BMaxInit : SMaxInit;
        if (ends) done_d = 1'b1;
      end
    end

    win_valid_d = win_valid_q;
    if (in_ready_o) win_valid_d = close_fire;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q      <= StartReset;
      fill_q      <= '0;
      col_q       <= '0;
      min_q       <= SMinInit;
      max_q       <= SMaxInit;
      done_q      <= 1'b0;
      win_valid_q <= 1'b0;
    end else begin
      skip_q      <= skip_d;
      fill_q      <= fill_d;
      col_q       <= col_d;
      min_q       <= min_d;
      max_q       <= max_d;
      done_q      <= done_d;
      win_valid_q <= win_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

endmodule

// ===== rtl/mmwd_scale.sv =====
module mmwd_scale
  import mmwd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic win_valid_i,
  input  win_t win_i,
  output logic win_ready_o,
  output logic row_valid_o,
  output row_t row_o,
  input  logic row_ready_i
);

  logic         row_valid_q;
  row_t         row_q, row_d;
  logic         take;
  logic [SampleW-1:0]      umin, umax;
  logic [SampleW+RowW-1:0] pmin, pmax;

  assign win_ready_o = !row_valid_q || row_ready_i;
  assign take        = win_valid_i && win_ready_o;
  assign row_valid_o = row_valid_q;
  assign row_o       = row_q;

  // Map both modes onto a 16-bit fraction: byte v becomes v<<8, sample s
  // becomes s+32768; the row is then H - (u*H >> 16).
  always_comb begin
    umin = cfg_i.byte_mode ? {win_i.vmin[7:0], 8'h00} : (win_i.vmin ^ SignFlip);
    umax = cfg_i.byte_mode ? {win_i.vmax[7:0], 8'h00} : (win_i.vmax ^ SignFlip);
    pmin = {{RowW{1'b0}}, umin} * {{SampleW{1'b0}}, cfg_i.height};
    pmax = {{RowW{1'b0}}, umax} * {{SampleW{1'b0}}, cfg_i.height};
    row_d.row_min = cfg_i.height - pmin[SampleW+RowW-1:SampleW];
    row_d.row_max = cfg_i.height - pmax[SampleW+RowW-1:SampleW];
    row_d.col     = win_i.col;
    row_d.ends    = win_i.ends;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= 1'b0;
    end else if (win_ready_o) begin
      row_valid_q <= take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) row_q <= row_d;
  end

endmodule

// ===== rtl/mmwd_seg.sv =====
module mmwd_seg
  import mmwd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  restart_t restart_i,
  input  logic     row_valid_i,
  input  row_t     row_i,
  output logic     row_ready_o,
  output logic     seg_valid_o,
  output seg_t     seg_o,
  input  logic     seg_ready_i
);

  logic            seg_valid_q, seg_valid_d;
  seg_t            seg_q, seg_d;
  logic [ColW-1:0] prev_col_q, prev_col_d;
  logic [RowW-1:0] prev_row_q, prev_row_d;
  logic            take;
  logic            emit;

  assign row_ready_o = !seg_valid_q || seg_ready_i;
  assign take        = row_valid_i && row_ready_o;
  assign seg_valid_o = seg_valid_q;
  assign seg_o       = seg_q;

  always_comb begin
    seg_d      = seg_q;
    prev_col_d = prev_col_q;
    prev_row_d = prev_row_q;
    emit       = 1'b0;

    if (row_i.row_min != row_i.row_max) begin
      // vertical span at this column
      emit          = 1'b1;
      seg_d.x_start = row_i.col;
      seg_d.y_start = row_i.row_min;
    end else if (prev_row_q != '0) begin
      // flat window: link from the previous point
      emit          = 1'b1;
      seg_d.x_start = prev_col_q;
      seg_d.y_start = prev_row_q;
    end
    seg_d.x_end         = row_i.col;
    seg_d.y_end         = row_i.row_max;
    seg_d.final_segment = row_i.ends;

    if (restart_i.start) begin
      prev_col_d = '0;
      prev_row_d = '0;
    end else if (take) begin
      prev_col_d = row_i.col;
      prev_row_d = row_i.row_max;
    end

    seg_valid_d = seg_valid_q;
    if (row_ready_o) seg_valid_d = take && emit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_valid_q <= 1'b0;
      prev_col_q  <= '0;
      prev_row_q  <= '0;
    end else begin
      seg_valid_q <= seg_valid_d;
      prev_col_q  <= prev_col_d;
      prev_row_q  <= prev_row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && emit) seg_q <= seg_d;
  end

endmodule

// ===== rtl/min_max_waveform_decimator.sv =====
// Path: a word that closes a window is registered in the accumulator record,
//   then in the scaler row register, then, if it yields a segment, in the output.
// Throughput: one sample word per cycle while not back-pressured; set by the
//   min/max update in the accumulator, with two 16x13 multipliers in the scaler.
// Reset: asynchronous, active low; registers return to their defaults and
//   the trace restarts. A write to a used register index also restarts the trace.
module min_max_waveform_decimator
  import mmwd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDatW-1:0]  cfg_wdata_i,
  mmwd_stream_if.sink         smp_i,
  mmwd_stream_if.source       seg_o
);

  // Pipeline:
  //   accum - skips the start offset, tracks min/max per window, counts
  //           columns; a closing window lands in its record register.
  //   scale - maps both extremes to screen rows (one multiply each).
  //   seg   - chooses span / link / nothing and holds the previous point;
  //           its register is the output request.
  // Each stage frees its register when the next one takes it, so a new
  // request is taken while an earlier segment still waits downstream.

  cfg_t     cfg_q, cfg_d;
  restart_t restart;

  logic win_valid, win_ready;
  win_t win;
  logic row_valid, row_ready;
  row_t row;
  smp_t smp_data;
  seg_t seg_data;

  // Register file; a write to an unused index changes nothing and does not
  // restart the trace.
  always_comb begin
    cfg_d         = cfg_q;
    restart.start = 1'b0;
    if (cfg_we_i) begin
      restart.start = 1'b1;
      case (cfg_reg_e'(cfg_idx_i))
        REG_SPP:    cfg_d.spp       = cfg_wdata_i[15:0];
        REG_PA:     cfg_d.pa        = cfg_wdata_i[CountW-1:0];
        REG_HEIGHT: cfg_d.height    = cfg_wdata_i[RowW-1:0];
        REG_START:  cfg_d.start     = cfg_wdata_i[SkipW-1:0];
        REG_BYTE:   cfg_d.byte_mode = cfg_wdata_i[0];
        default:    restart.start   = 1'b0;
      endcase
    end
    restart.cfg = cfg_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.spp       <= SppReset;
      cfg_q.pa        <= PaReset;
      cfg_q.height    <= HeightReset;
      cfg_q.start     <= StartReset;
      cfg_q.byte_mode <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign smp_data   = smp_i.data;
  assign seg_o.data = seg_data;

  mmwd_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .restart_i   (restart),
    .in_valid_i  (smp_i.valid),
    .in_data_i   (smp_data),
    .in_ready_o  (smp_i.ready),
    .win_valid_o (win_valid),
    .win_o       (win),
    .win_ready_i (win_ready)
  );

  mmwd_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .win_valid_i (win_valid),
    .win_i       (win),
    .win_ready_o (win_ready),
    .row_valid_o (row_valid),
    .row_o       (row),
    .row_ready_i (row_ready)
  );

  mmwd_seg u_seg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .restart_i   (restart),
    .row_valid_i (row_valid),
    .row_i       (row),
    .row_ready_o (row_ready),
    .seg_valid_o (seg_o.valid),
    .seg_o       (seg_data),
    .seg_ready_i (seg_o.ready)
  );

endmodule
